FILE: src/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

  // ASCII codes, cut to the six bits the output carries.
  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  // The smallest BCD digit that needs the +3 correction before a shift.
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_DIGITS
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
    logic emit_sign;
    logic emit_digit;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic top_zero;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/sitda_dp.sv
`default_nettype none

module sitda_dp #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [VALUE_BITS-1:0]   value_i,
  input  wire sitda_pkg::dp_cmd_t      cmd_i,
  output      sitda_pkg::dp_status_t   status_o,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [5:0]              char_code_o,
  output      logic                    last_char_o
);
  import sitda_pkg::*;

  // Enough decimal digits for any magnitude of VALUE_BITS bits.
  localparam int NumDigits = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BcdBits   = NumDigits * 4;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdBits-1:0]    bcd_q, bcd_d;
  logic [BcdBits-1:0]    bcd_adj;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] neg_mag;
  logic [3:0]            top_digit;
  logic                  out_valid_q, out_valid_d;
  logic [5:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic                  out_free;

  assign neg_mag   = ~value_i + {{(VALUE_BITS-1){1'b0}}, 1'b1};
  assign top_digit = bcd_q[BcdBits-1 -: 4];
  assign out_free  = !out_valid_q || !out_stall_i;

  // Double dabble: correct every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*4 +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      neg_d = value_i[VALUE_BITS-1];
      bin_d = value_i[VALUE_BITS-1] ? neg_mag : value_i;
      bcd_d = '0;
    end else if (cmd_i.dabble) begin
      bcd_d = {bcd_adj[BcdBits-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
    end else if (cmd_i.shift_digit) begin
      bcd_d = {bcd_q[BcdBits-5:0], 4'b0000};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      char_d      = CHAR_MINUS;
      last_d      = 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      char_d      = CHAR_ZERO + {2'b00, top_digit};
      last_d      = cmd_i.last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.neg      = neg_q;
  assign status_o.top_zero = (top_digit == 4'd0);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

FILE: src/sitda_ctrl.sv
`default_nettype none

module sitda_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire sitda_pkg::dp_status_t  status_i,
  output      sitda_pkg::dp_cmd_t     cmd_o
);
  import sitda_pkg::*;

  localparam int NumDigits = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int CntBits   = $clog2(VALUE_BITS);

  ctrl_state_e        state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               started_q, started_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntBits'(VALUE_BITS - 1);
          state_d    = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd_o.dabble = 1'b1;
        if (cnt_q == '0) begin
          cnt_d     = CntBits'(NumDigits - 1);
          started_d = 1'b0;
          state_d   = status_i.neg ? ST_SIGN : ST_DIGITS;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        // Leading zeros are dropped, but the units digit always goes out.
        if (status_i.top_zero && !started_q && (cnt_q != '0)) begin
          cmd_o.shift_digit = 1'b1;
          cnt_d             = cnt_q - 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit_digit  = 1'b1;
          cmd_o.shift_digit = 1'b1;
          cmd_o.last        = (cnt_q == '0);
          started_d         = 1'b1;
          if (cnt_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

FILE: src/signed_int_to_decimal_ascii_unit.sv
// Converts a two's complement integer into its decimal ASCII text.
// Input channel: value_i with in_valid_i / in_stall_o. A transaction takes
// place at a clock edge where in_valid_i is high and in_stall_o is low.
// Output channel: char_code_o and last_char_o with out_valid_o / out_stall_i.
// Each output transaction carries one character, most significant first:
// an optional minus sign (45), then the digits (48..57) with no leading
// zeros. last_char_o marks the final character of a number.
// One item goes through a load, VALUE_BITS double-dabble shifts, a minus
// sign if negative, and then a walk over every BCD digit position
// (((VALUE_BITS*1233)>>12)+1 positions, 10 at 32 bits), leading zeros
// being skipped in that walk. One item is in work at a time; the next
// is taken while the last character still sits in the output register.
// A stall from the receiver holds the output register and pauses the
// character walk. Reset (rst_ni low, asynchronous) returns the controller to
// idle and empties the output register.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [5:0]            char_code_o,
  output      logic                  last_char_o
);
  import sitda_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sitda_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sitda_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

endmodule

`default_nettype wire

FILE: src/sitda_checker.sv
`default_nettype none

module sitda_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [5:0] char_code_o,
  input wire logic       last_char_o
);
  import sitda_pkg::*;

  // A stalled output transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(char_code_o) && $stable(last_char_o))
    else $error("stalled output changed");

  // Only the minus sign and the ten digits ever appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CHAR_MINUS) ||
      ((char_code_o >= CHAR_ZERO) && (char_code_o <= CHAR_ZERO + 6'd9)))
    else $error("illegal character code");

  // A minus sign is always followed by at least one digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_code_o == CHAR_MINUS) |-> !last_char_o)
    else $error("minus sign marked as last character");

  // Once an item is taken the block is busy converting it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input accepted again during conversion");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .char_code_o(char_code_o),
  .last_char_o(last_char_o)
);

`default_nettype wire
